>>> design/h2r_pkg.sv
// Shared types and constants for the HSL to RGB converter.
package h2r_pkg;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned T_W    = 10;
	localparam int unsigned TEMP_W = 16;
	localparam int unsigned SEG_W  = 8;
	localparam int unsigned PROD_W = TEMP_W + SEG_W;
	localparam int unsigned V_W    = 23;

	// Hue positions in units of 1/768 of a turn.
	localparam logic [T_W-1:0] T_SIXTH      = 10'd128;
	localparam logic [T_W-1:0] T_THIRD      = 10'd256;
	localparam logic [T_W-1:0] T_HALF       = 10'd384;
	localparam logic [T_W-1:0] T_TWO_THIRDS = 10'd512;
	localparam logic [T_W-1:0] T_FULL       = 10'd768;

	// Ramp weight on the plateau, equal to the full ramp length.
	localparam logic [SEG_W-1:0] SEG_FULL = 8'd128;

	// Load enables of the stages after the first.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic out;
	} pipe_en_t;

endpackage

>>> design/h2r_channel.sv
// One color channel: ramp weight, span product, channel value and scale to 255.
module h2r_channel (
	input  logic                            clk,
	input  h2r_pkg::pipe_en_t               en,
	input  logic [h2r_pkg::T_W-1:0]         t_s1,
	input  logic [h2r_pkg::TEMP_W-1:0]      hi_s2,
	input  logic [h2r_pkg::TEMP_W-1:0]      lo_s2,
	input  logic [h2r_pkg::TEMP_W-1:0]      lo_s3,
	input  logic                            grey_s3,
	input  logic [h2r_pkg::CH_W-1:0]        light_s3,
	output logic [h2r_pkg::CH_W-1:0]        value
);

	logic [h2r_pkg::SEG_W-1:0]  seg;
	logic [h2r_pkg::SEG_W-1:0]  seg_s2;
	logic [h2r_pkg::T_W-1:0]    fall;
	logic [h2r_pkg::TEMP_W-1:0] span;
	logic [h2r_pkg::PROD_W-1:0] prod_s3;
	logic [h2r_pkg::V_W-1:0]    v;
	logic [h2r_pkg::V_W-1:0]    v_s4;
	logic [h2r_pkg::V_W+7:0]    scaled;
	logic [h2r_pkg::CH_W-1:0]   value_q;

	// Weight of the span: rising ramp, plateau, falling ramp, floor.
	always_comb begin
		fall = h2r_pkg::T_TWO_THIRDS - t_s1;
		if (t_s1 < h2r_pkg::T_SIXTH) begin
			seg = t_s1[h2r_pkg::SEG_W-1:0];
		end else if (t_s1 < h2r_pkg::T_HALF) begin
			seg = h2r_pkg::SEG_FULL;
		end else if (t_s1 < h2r_pkg::T_TWO_THIRDS) begin
			seg = fall[h2r_pkg::SEG_W-1:0];
		end else begin
			seg = '0;
		end
	end

	assign span = hi_s2 - lo_s2;

	always_comb begin
		if (grey_s3) begin
			v = {light_s3, 15'd0};
		end else begin
			v = {lo_s3, 7'd0} + prod_s3[h2r_pkg::V_W-1:0];
		end
	end

	// v * 255 as v * 256 - v; the top eight bits are the channel.
	assign scaled = {v_s4, 8'd0} - {8'd0, v_s4};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			seg_s2 <= seg;
		end
		if (en.s3) begin
			prod_s3 <= {8'd0, span} * {16'd0, seg_s2};
		end
		if (en.s4) begin
			v_s4 <= v;
		end
		if (en.out) begin
			value_q <= scaled[h2r_pkg::V_W+7:h2r_pkg::V_W];
		end
	end

	assign value = value_q;

endmodule

>>> design/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter.
//
// Usage: an HSL pixel enters on the s_axis channel and leaves as an RGB pixel on
// the m_axis channel. A transfer happens at a rising edge where tvalid and tready
// are both high. Input tdata carries hue, saturation and lightness from the
// lowest byte up; output tdata carries red, green and blue in the same way.
// Zero saturation gives a grey pixel; otherwise the usual two-temporary HSL
// method applies, computed exactly in fixed point with one final floor.
// The pixel is loaded at the transfer edge into the first of four pipeline
// stages (hue offsets and L*S product, temporaries, span products, channel
// values) and then passes through the other three and the output register in
// turn before it appears on the m_axis channel. Throughput is one pixel per
// clock while the receiver is ready, set by the pipeline that takes a new pixel
// every cycle. When the receiver stalls, each stage holds its pixel only while
// the stage after it is full, so empty slots close up and the input keeps
// taking pixels until every stage is occupied. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
module hsl_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // hue [7:0], saturation [15:8], lightness [23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // red [7:0], green [15:8], blue [23:16]
);

	logic [h2r_pkg::CH_W-1:0] hue;
	logic [h2r_pkg::CH_W-1:0] saturation;
	logic [h2r_pkg::CH_W-1:0] lightness;

	logic en_s1;
	h2r_pkg::pipe_en_t en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, rgb_valid_q;

	// First stage: channel hue positions and the L*S product.
	logic [h2r_pkg::T_W-1:0] tg, tr_sum, tr, tb;
	logic [h2r_pkg::T_W-1:0] tr_s1, tg_s1, tb_s1;
	logic [h2r_pkg::TEMP_W-1:0] ls_s1;
	logic [h2r_pkg::CH_W-1:0]   sat_s1, light_s1;
	logic                       grey_s1;

	// Second stage: the two temporaries.
	logic [h2r_pkg::TEMP_W:0]   hi_wide, lo_wide;
	logic [h2r_pkg::TEMP_W-1:0] hi_s2, lo_s2;
	logic                       grey_s2;
	logic [h2r_pkg::CH_W-1:0]   light_s2;

	// Third stage: what the channel value stage needs besides the products.
	logic [h2r_pkg::TEMP_W-1:0] lo_s3;
	logic                       grey_s3;
	logic [h2r_pkg::CH_W-1:0]   light_s3;

	logic [h2r_pkg::CH_W-1:0] red, green, blue;

	assign hue        = s_axis_tdata[7:0];
	assign saturation = s_axis_tdata[15:8];
	assign lightness  = s_axis_tdata[23:16];

	// A stage loads when it is empty or its contents move on in this cycle.
	assign en.out = !rgb_valid_q || m_axis_tready;
	assign en.s4  = !vld_s4 || en.out;
	assign en.s3  = !vld_s3 || en.s4;
	assign en.s2  = !vld_s2 || en.s3;
	assign en_s1  = !vld_s1 || en.s2;
	assign s_axis_tready = en_s1;

	// Green sits at 3*hue; red is a third ahead and blue a third behind, wrapped.
	always_comb begin
		tg     = {2'b00, hue} + {1'b0, hue, 1'b0};
		tr_sum = tg + h2r_pkg::T_THIRD;
		if (tr_sum > h2r_pkg::T_FULL) begin
			tr = tr_sum - h2r_pkg::T_FULL;
		end else begin
			tr = tr_sum;
		end
		if (tg >= h2r_pkg::T_THIRD) begin
			tb = tg - h2r_pkg::T_THIRD;
		end else begin
			tb = tg + h2r_pkg::T_TWO_THIRDS;
		end
	end

	// The upper temporary depends on which half the lightness is in; the lower
	// one is twice the lightness minus the upper one, both in units of 1/65536.
	always_comb begin
		if (!light_s1[7]) begin
			hi_wide = {1'b0, light_s1, 8'd0} + {1'b0, ls_s1};
		end else begin
			hi_wide = {({1'b0, light_s1} + {1'b0, sat_s1}), 8'd0} - {1'b0, ls_s1};
		end
		lo_wide = {light_s1, 9'd0} - {1'b0, hi_wide[h2r_pkg::TEMP_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			rgb_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (en.s2) begin
				vld_s2 <= vld_s1;
			end
			if (en.s3) begin
				vld_s3 <= vld_s2;
			end
			if (en.s4) begin
				vld_s4 <= vld_s3;
			end
			if (en.out) begin
				rgb_valid_q <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tr_s1    <= tr;
			tg_s1    <= tg;
			tb_s1    <= tb;
			ls_s1    <= {8'd0, saturation} * {8'd0, lightness};
			sat_s1   <= saturation;
			light_s1 <= lightness;
			grey_s1  <= (saturation == '0);
		end
		if (en.s2) begin
			hi_s2    <= hi_wide[h2r_pkg::TEMP_W-1:0];
			lo_s2    <= lo_wide[h2r_pkg::TEMP_W-1:0];
			grey_s2  <= grey_s1;
			light_s2 <= light_s1;
		end
		if (en.s3) begin
			lo_s3    <= lo_s2;
			grey_s3  <= grey_s2;
			light_s3 <= light_s2;
		end
	end

	h2r_channel u_red (
		.clk      (clk),
		.en       (en),
		.t_s1     (tr_s1),
		.hi_s2    (hi_s2),
		.lo_s2    (lo_s2),
		.lo_s3    (lo_s3),
		.grey_s3  (grey_s3),
		.light_s3 (light_s3),
		.value    (red)
	);

	h2r_channel u_green (
		.clk      (clk),
		.en       (en),
		.t_s1     (tg_s1),
		.hi_s2    (hi_s2),
		.lo_s2    (lo_s2),
		.lo_s3    (lo_s3),
		.grey_s3  (grey_s3),
		.light_s3 (light_s3),
		.value    (green)
	);

	h2r_channel u_blue (
		.clk      (clk),
		.en       (en),
		.t_s1     (tb_s1),
		.hi_s2    (hi_s2),
		.lo_s2    (lo_s2),
		.lo_s3    (lo_s3),
		.grey_s3  (grey_s3),
		.light_s3 (light_s3),
		.value    (blue)
	);

	assign m_axis_tvalid = rgb_valid_q;
	assign m_axis_tdata  = {blue, green, red};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HSL to RGB converter stream block.
module testbench;

	// Hue positions in units of 1/768 of a turn.
	localparam logic [9:0] HUE_SIXTH      = 10'd128;
	localparam logic [9:0] HUE_THIRD      = 10'd256;
	localparam logic [9:0] HUE_HALF       = 10'd384;
	localparam logic [9:0] HUE_TWO_THIRDS = 10'd512;
	localparam logic [9:0] HUE_TURN       = 10'd768;

	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned DRAIN_CYCLES = 20;

	// Packed so that the layout matches m_axis_tdata: red in the lowest byte.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct {
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] light;
		rgb_t       rgb;
	} pixel_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // hue [7:0], saturation [15:8], lightness [23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // red [7:0], green [15:8], blue [23:16]

	pixel_entry_t rgb_pending[$];

	int unsigned pixels_sent = 0;
	int unsigned grey_sent = 0;
	int unsigned pixels_checked = 0;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	bit          full_rate = 1'b0;

	hsl_to_rgb_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// One channel: rising ramp, plateau, falling ramp, floor. The value is kept
	// in units of 1/(65536*128) and floored once after scaling by 255.
	function automatic logic [7:0] channel_level(logic [9:0] t, logic [15:0] lo,
			logic [15:0] hi);
		logic [15:0] span;
		logic [39:0] v;
		logic [39:0] scaled;
		span = hi - lo;
		if (t < HUE_SIXTH) begin
			v = 40'(lo) * 40'd128 + 40'(span) * 40'(t);
		end else if (t < HUE_HALF) begin
			v = 40'(hi) * 40'd128;
		end else if (t < HUE_TWO_THIRDS) begin
			v = 40'(lo) * 40'd128 + 40'(span) * 40'(HUE_TWO_THIRDS - t);
		end else begin
			v = 40'(lo) * 40'd128;
		end
		scaled = v * 40'd255;
		return scaled[30:23];
	endfunction

	function automatic rgb_t hsl_pixel_to_rgb(logic [7:0] h, logic [7:0] s, logic [7:0] l);
		logic [31:0] hi_t;
		logic [31:0] lo_t;
		logic [31:0] grey;
		logic [9:0]  t_green;
		logic [9:0]  t_red;
		logic [9:0]  t_blue;
		rgb_t        px;
		if (s == 8'd0) begin
			grey = (32'(l) * 32'd255) >> 8;
			px.red = grey[7:0];
			px.green = grey[7:0];
			px.blue = grey[7:0];
			return px;
		end
		// Temporaries in units of 1/65536.
		if (l < 8'd128) begin
			hi_t = 32'(l) * (32'd256 + 32'(s));
		end else begin
			hi_t = 32'd256 * (32'(l) + 32'(s)) - 32'(l) * 32'(s);
		end
		lo_t = 32'd512 * 32'(l) - hi_t;
		// Red sits a third of a turn ahead of green, blue a third behind.
		t_green = 10'(3 * 32'(h));
		t_red = t_green + HUE_THIRD;
		if (t_red > HUE_TURN) begin
			t_red = t_red - HUE_TURN;
		end
		t_blue = (t_green >= HUE_THIRD) ? t_green - HUE_THIRD : t_green + HUE_TWO_THIRDS;
		px.red = channel_level(t_red, lo_t[15:0], hi_t[15:0]);
		px.green = channel_level(t_green, lo_t[15:0], hi_t[15:0]);
		px.blue = channel_level(t_blue, lo_t[15:0], hi_t[15:0]);
		return px;
	endfunction

	// Receiver: alternates ready and stall stretches of random length, mostly
	// short stalls with the odd long one. Always ready during full-rate phases.
	always @(posedge clk) begin : receiver_pattern
		int unsigned run_left;
		bit          ready_phase;
		logic        next_ready;
		if (full_rate) begin
			next_ready = 1'b1;
		end else begin
			if (run_left == 0) begin
				ready_phase = ~ready_phase;
				if (ready_phase) begin
					run_left = $urandom_range(1, 16);
				end else if ($urandom_range(0, 4) == 0) begin
					run_left = $urandom_range(5, 24);
				end else begin
					run_left = $urandom_range(1, 3);
				end
			end
			run_left = run_left - 1;
			next_ready = ready_phase;
		end
		m_axis_tready <= next_ready;
	end

	// Result checker. Outputs are sampled at the falling edge; a result seen
	// with valid and ready high there is the transfer of the next rising edge.
	always @(negedge clk) begin : rgb_checker
		pixel_entry_t want;
		rgb_t         got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (rgb_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("ERROR: unexpected result r=%0d g=%0d b=%0d at %0t",
						got.red, got.green, got.blue, $realtime);
				end
			end else begin
				want = rgb_pending.pop_front();
				pixels_checked++;
				if (got.red !== want.rgb.red || got.green !== want.rgb.green ||
						got.blue !== want.rgb.blue) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR: hsl (%0d,%0d,%0d) expected rgb (%0d,%0d,%0d) got (%0d,%0d,%0d)",
							want.hue, want.sat, want.light,
							want.rgb.red, want.rgb.green, want.rgb.blue,
							got.red, got.green, got.blue);
					end
				end
			end
		end
	end

	// Sends one pixel. Called just after a rising edge; returns just after the
	// edge at which the transfer took place.
	task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] l);
		int unsigned  gap;
		pixel_entry_t entry;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!full_rate) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {l, s, h};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		entry.hue = h;
		entry.sat = s;
		entry.light = l;
		entry.rgb = hsl_pixel_to_rgb(h, s, l);
		rgb_pending.push_back(entry);
		pixels_sent++;
		if (s == 8'd0) begin
			grey_sent++;
		end
		burst_left--;
	endtask

	// Random pixel, biased toward grey, full saturation, lightness extremes and
	// hues that land on or beside a segment boundary.
	task automatic random_pixel(output logic [7:0] h, output logic [7:0] s,
			output logic [7:0] l);
		logic [7:0] edge_hues[10] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86,
			8'd127, 8'd128, 8'd170, 8'd171, 8'd255};
		logic [7:0] edge_lights[4] = '{8'd0, 8'd127, 8'd128, 8'd255};
		h = ($urandom_range(0, 4) == 0) ? edge_hues[$urandom_range(0, 9)] : 8'($urandom);
		s = 8'($urandom);
		l = 8'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				s = 8'd0;
			end
			1: begin
				s = 8'd255;
			end
			2: begin
				l = edge_lights[$urandom_range(0, 3)];
			end
			default: begin
			end
		endcase
	endtask

	// Grey at the lightness extremes and the midpoint, full saturation and
	// lightness, and hues either side of every breakpoint and wrap point.
	task automatic test_corner_pixels();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd200, 8'd0, 8'd255);
		send_pixel(8'd17, 8'd0, 8'd127);
		send_pixel(8'd255, 8'd0, 8'd128);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd128);
		send_pixel(8'd0, 8'd255, 8'd127);
		send_pixel(8'd0, 8'd1, 8'd1);
		send_pixel(8'd42, 8'd200, 8'd100);
		send_pixel(8'd43, 8'd200, 8'd100);
		send_pixel(8'd85, 8'd200, 8'd160);
		send_pixel(8'd86, 8'd200, 8'd160);
		send_pixel(8'd127, 8'd180, 8'd90);
		send_pixel(8'd128, 8'd180, 8'd90);
		send_pixel(8'd170, 8'd255, 8'd200);
		send_pixel(8'd171, 8'd255, 8'd200);
		send_pixel(8'd213, 8'd128, 8'd64);
		send_pixel(8'd214, 8'd128, 8'd64);
		send_pixel(8'd255, 8'd1, 8'd254);
		send_pixel(8'd170, 8'd255, 8'd0);
		send_pixel(8'd85, 8'd255, 8'd255);
	endtask

	task automatic test_random_pixels(input int unsigned count);
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] l;
		repeat (count) begin
			random_pixel(h, s, l);
			send_pixel(h, s, l);
		end
	endtask

	// Back-to-back transfers with the receiver always ready.
	task automatic test_full_rate(input int unsigned count);
		full_rate = 1'b1;
		burst_left = count + 1;
		test_random_pixels(count);
		full_rate = 1'b0;
		burst_left = 0;
	endtask

	// Every so often the sender stops until the pipeline has emptied.
	task automatic test_drain_pauses(input int unsigned count);
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] l;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 39) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (rgb_pending.size() != 0);
				burst_left = 0;
			end
			random_pixel(h, s, l);
			send_pixel(h, s, l);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_pixels();
		test_random_pixels(1000);
		test_full_rate(250);
		test_drain_pauses(200);
		s_axis_tvalid <= 1'b0;
		while (rgb_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rgb_pending.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d results never arrived", rgb_pending.size());
		end
		$display("Sent %0d pixels (%0d grey) and compared %0d RGB results, %0d mismatching.",
			pixels_sent, grey_sent, pixels_checked, mismatches);
		$display("Covered segment boundaries, hue wrap, extremes, stalls, gaps and full rate.");
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
